FILE: rtl/rhhl_pkg.sv
// Shared types, constants and codes for the Robin Hood hash lookup block.
package rhhl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int DIST_W = ADDR_W + 1;
    // Largest power of two that still fits in the table, as a log2.
    localparam int CAP_LOG2_MAX = $clog2(TABLE_DEPTH + 1) - 1;

    localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_CAP_LOG2 = 1'b0;
    localparam logic REG_VALID_ENTRIES = 1'b1;
    localparam logic [3:0] CAP_LOG2_RESET = 4'd12;

    typedef struct packed {
        logic        mode;
        logic [11:0] slot;
        logic [31:0] key;
        logic [31:0] entry_index;
    } rhhl_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_index;
    } rhhl_out_t;

    typedef struct packed {
        logic [3:0]  capacity_log2;
        logic [31:0] valid_entries;
    } rhhl_cfg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_READ,
        S_RDATA,
        S_RHASH1,
        S_RHASH2,
        S_DONE
    } rhhl_state_t;

endpackage

FILE: rtl/rhhl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module rhhl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rhhl_mix.sv
// Two-stage pipelined 32-bit xor-shift-multiply hash mixer.
module rhhl_mix
    import rhhl_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] din,
    output logic [31:0] dout
);

    logic [31:0] m1_reg;
    logic [31:0] m1_next;
    logic [31:0] m2_reg;
    logic [31:0] m2_next;
    logic [31:0] x1;
    logic [31:0] x2;

    always_comb
    begin
        x1 = din ^ (din >> 16);
        m1_next = x1 * MIX_MUL_A;
        x2 = m1_reg ^ (m1_reg >> 15);
        m2_next = x2 * MIX_MUL_B;
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= m1_next;
        m2_reg <= m2_next;
    end

    assign dout = m2_reg ^ (m2_reg >> 16);

endmodule

FILE: rtl/rhhl_cfg.sv
// APB-style configuration registers for capacity and entry count.
module rhhl_cfg
    import rhhl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output rhhl_cfg_t             cfg
);

    logic [3:0]  cap_log2_reg;
    logic [3:0]  cap_log2_next;
    logic [31:0] valid_entries_reg;
    logic [31:0] valid_entries_next;
    logic        wr_en;
    logic        reg_sel;

    always_comb
    begin
        reg_sel = paddr[2];
        wr_en = psel & penable & pwrite;
        cap_log2_next = cap_log2_reg;
        valid_entries_next = valid_entries_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_CAP_LOG2:      cap_log2_next = pwdata[3:0];
                REG_VALID_ENTRIES: valid_entries_next = pwdata;
                default:           cap_log2_next = cap_log2_reg;
            endcase
        end
        case (reg_sel)
            REG_CAP_LOG2:      prdata = {28'd0, cap_log2_reg};
            REG_VALID_ENTRIES: prdata = valid_entries_reg;
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_log2_reg <= CAP_LOG2_RESET;
            valid_entries_reg <= 32'd0;
        end
        else
        begin
            cap_log2_reg <= cap_log2_next;
            valid_entries_reg <= valid_entries_next;
        end
    end

    assign pready = 1'b1;
    assign cfg.capacity_log2 = cap_log2_reg;
    assign cfg.valid_entries = valid_entries_reg;

endmodule

FILE: rtl/robin_hood_hash_lookup.sv
// Robin Hood hash table lookup. After reset the block sweeps the key memory to
// empty, one slot per cycle, before in_ready rises; configuration writes are
// taken during the sweep. A load transaction writes one slot. A lookup first
// hashes the key, then probes slots in turn: each probe is one read of the slot
// memories and a pass of the resident key through the two-stage hash mixer,
// which is shared with the home hash; a probe that hits an empty slot ends after
// its read. One item is worked on at a time; a finished result sits in the
// output register while loads go on.
module robin_hood_hash_lookup
    import rhhl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rhhl_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rhhl_out_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    rhhl_cfg_t   cfg;
    rhhl_state_t state_reg;
    rhhl_state_t state_next;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic [31:0]       key_reg;
    logic [31:0]       key_next;
    logic [1:0]        res_status_reg;
    logic [1:0]        res_status_next;
    logic [31:0]       res_index_reg;
    logic [31:0]       res_index_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rhhl_out_t         out_data_reg;
    rhhl_out_t         out_data_next;

    logic              key_we;
    logic [ADDR_W-1:0] key_waddr;
    logic [31:0]       key_wdata;
    logic              idx_we;
    logic              mem_re;
    logic [31:0]       key_rdata;
    logic [31:0]       idx_rdata;
    logic [31:0]       mix_din;
    logic [31:0]       mix_dout;

    logic [3:0]        eff_log2;
    logic [31:0]       cap_w;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] rdist;
    logic [DIST_W-1:0] dist_inc;
    logic [31:0]       slot_w;
    logic              accept;

    rhhl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rhhl_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (mem_re),
        .raddr (pos_reg),
        .rdata (key_rdata)
    );

    rhhl_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_idx_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (key_waddr),
        .wdata (in_data.entry_index),
        .re    (mem_re),
        .raddr (pos_reg),
        .rdata (idx_rdata)
    );

    rhhl_mix u_mix (
        .clk  (clk),
        .din  (mix_din),
        .dout (mix_dout)
    );

    // Capacity in use is clamped to the largest power of two that fits the table.
    always_comb
    begin
        if (int'(cfg.capacity_log2) > CAP_LOG2_MAX)
        begin
            eff_log2 = 4'(CAP_LOG2_MAX);
        end
        else
        begin
            eff_log2 = cfg.capacity_log2;
        end
        cap_w = 32'd1 << eff_log2;
        mask = cap_w[ADDR_W-1:0] - 1'b1;
        rdist = (pos_reg - mix_dout[ADDR_W-1:0]) & mask;
        dist_inc = dist_reg + 1'b1;
        slot_w = 32'(in_data.slot);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid & in_ready;
    assign mix_din = (state_reg == S_RDATA) ? key_rdata : in_data.key;

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pos_next = pos_reg;
        dist_next = dist_reg;
        key_next = key_reg;
        res_status_next = res_status_reg;
        res_index_next = res_index_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        key_we = 1'b0;
        idx_we = 1'b0;
        key_waddr = slot_w[ADDR_W-1:0];
        key_wdata = in_data.key;
        mem_re = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                key_we = 1'b1;
                key_waddr = clr_cnt_reg;
                key_wdata = 32'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == 32'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_LOAD)
                    begin
                        if (slot_w < 32'(TABLE_DEPTH))
                        begin
                            key_we = 1'b1;
                            idx_we = 1'b1;
                        end
                    end
                    else
                    begin
                        key_next = in_data.key;
                        state_next = S_HASH1;
                    end
                end
            end
            S_HASH1:
            begin
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                pos_next = mix_dout[ADDR_W-1:0] & mask;
                dist_next = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                mem_re = 1'b1;
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (key_rdata == 32'd0)
                begin
                    res_status_next = STATUS_MISS;
                    res_index_next = 32'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RHASH1;
                end
            end
            S_RHASH1:
            begin
                state_next = S_RHASH2;
            end
            S_RHASH2:
            begin
                // The memory outputs still hold this slot: no read was issued since.
                if ({1'b0, rdist} < dist_reg)
                begin
                    res_status_next = STATUS_MISS;
                    res_index_next = 32'd0;
                    state_next = S_DONE;
                end
                else if (key_rdata == key_reg)
                begin
                    res_status_next = (idx_rdata < cfg.valid_entries) ? STATUS_FOUND
                                                                      : STATUS_RANGE;
                    res_index_next = idx_rdata;
                    state_next = S_DONE;
                end
                else if (dist_inc == cap_w[DIST_W-1:0])
                begin
                    res_status_next = STATUS_MISS;
                    res_index_next = 32'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = (pos_reg + 1'b1) & mask;
                    dist_next = dist_inc;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.status = res_status_reg;
                    out_data_next.match_index = res_index_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        dist_reg <= dist_next;
        key_reg <= key_next;
        res_status_reg <= res_status_next;
        res_index_reg <= res_index_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule
